### hdl/u8d_pkg.sv
// shared types and constants of the utf-8 stream decoder
`timescale 1ns / 1ps
package u8d_pkg;

   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 21;
   localparam int SRC_W    = 3;
   localparam int DEPTH    = 3;
   localparam int REP_W    = 3;
   localparam int TAIL_W   = 2;

   localparam logic [CODE_W-1:0] REPL_CODE    = 21'h00FFFD;
   localparam logic [CODE_W-1:0] MIN_TWO      = 21'h000080;
   localparam logic [CODE_W-1:0] MIN_THREE    = 21'h000800;
   localparam logic [CODE_W-1:0] MIN_FOUR     = 21'h010000;
   localparam logic [CODE_W-1:0] MAX_CODE     = 21'h10FFFF;
   localparam logic [CODE_W-1:0] SURR_LO      = 21'h00D800;
   localparam logic [CODE_W-1:0] SURR_HI      = 21'h00DFFF;
   localparam logic [CODE_W-1:0] PLANE_OFFSET = 21'h010000;
   localparam logic [5:0]        HIGH_PREFIX  = 6'b110110;
   localparam logic [5:0]        LOW_PREFIX   = 6'b110111;

   // one result entry
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              rep;
      logic [SRC_W-1:0]  src;
   } u8d_entry_type;

   // decoder state: pending byte count, sequence length, pending bytes
   typedef struct packed {
      logic [1:0]                    count;
      logic [2:0]                    exp_len;
      logic [DEPTH-1:0][BYTE_W-1:0]  store;
   } u8d_state_type;

   // results of one byte: rep_cnt replacements, then up to two tail entries
   typedef struct packed {
      logic [REP_W-1:0]  rep_cnt;
      logic [TAIL_W-1:0] tail_cnt;
      u8d_entry_type     tail0;
      u8d_entry_type     tail1;
   } u8d_burst_type;

endpackage

### hdl/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder with replacement
`timescale 1ns / 1ps
//
//   channel  | direction | transfer when           | payload
//   ---------+-----------+-------------------------+-----------------------------------
//   req_     | in        | req_tvalid & req_tready | tdata: in_byte; tlast: in_last
//   rsp_     | out       | rsp_tvalid & rsp_tready | tdata: code_value, source_bytes;
//            |           |                         | tuser: is_replacement; tlast: run_end
//   csr_     | in        | csr_wen                 | wdata: utf16_mode
//
// one byte per cycle while rsp_tready is high and each byte gives at most one
// result; a byte that gives more results holds the output stage until its last
// result transfers, limited by the single result port
// a byte passes the input register, then the result stage, before its first result
// synchronous active-high reset clears pending count and length, mode and both stages
// the input register holds one byte while a result waits on a stalled rsp side,
// then req_tready stays low until the last result of the burst transfers
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wen,
   input  logic        csr_wdata,
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,
   // result stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [20:0] code_value, [23:21] source_bytes
   output logic        rsp_tuser,    // [0] is_replacement
   output logic        rsp_tlast
);
   import u8d_pkg::*;

   // mode register
   logic mode_ff;

   // input register stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // decoder state
   u8d_state_type state_ff, state_in;

   // result stage: remaining replacements and tail entries
   logic [REP_W-1:0]  rep_left_ff, rep_left_in;
   logic [TAIL_W-1:0] tail_left_ff, tail_left_in;
   u8d_entry_type     tail0_ff, tail0_in;
   u8d_entry_type     tail1_ff, tail1_in;

   u8d_burst_type burst;
   logic [3:0]    remaining;
   logic          out_xfer, out_final, advance;

   u8d_decode u_decode (
      .in_byte    (in_byte_ff),
      .in_last    (in_last_ff),
      .utf16_mode (mode_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_in),
      .burst      (burst)
   );

   assign remaining = {1'b0, rep_left_ff} + {2'b00, tail_left_ff};
   assign out_xfer  = rsp_tvalid && rsp_tready;
   assign out_final = (remaining == 4'd1);

   // the buffered byte moves on once the result stage is empty or drains now
   assign advance     = in_valid_ff && ((remaining == 4'd0) || (out_xfer && out_final));
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   // output: replacements first, then tail entries
   assign rsp_tvalid = (remaining != 4'd0);
   assign rsp_tlast  = out_final;
   always_comb begin
      if (rep_left_ff != '0) begin
         rsp_tdata = {3'd1, REPL_CODE};
         rsp_tuser = 1'b1;
      end else begin
         rsp_tdata = {tail0_ff.src, tail0_ff.code};
         rsp_tuser = tail0_ff.rep;
      end
   end

   always_comb begin
      rep_left_in  = rep_left_ff;
      tail_left_in = tail_left_ff;
      tail0_in     = tail0_ff;
      tail1_in     = tail1_ff;
      if (advance) begin
         rep_left_in  = burst.rep_cnt;
         tail_left_in = burst.tail_cnt;
         tail0_in     = burst.tail0;
         tail1_in     = burst.tail1;
      end else if (out_xfer) begin
         if (rep_left_ff != '0) begin
            rep_left_in = rep_left_ff - 3'd1;
         end else begin
            // low surrogate half moves up behind the high half
            tail_left_in = tail_left_ff - 2'd1;
            tail0_in     = tail1_ff;
         end
      end
   end

   // pending bytes are not cleared by reset, only count and length
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         in_valid_ff   <= 1'b0;
         state_ff.count   <= 2'd0;
         state_ff.exp_len <= 3'd0;
         rep_left_ff   <= '0;
         tail_left_ff  <= '0;
      end else begin
         if (csr_wen) begin
            mode_ff <= csr_wdata;
         end
         in_valid_ff <= in_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         rep_left_ff  <= rep_left_in;
         tail_left_ff <= tail_left_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      tail0_ff <= tail0_in;
      tail1_ff <= tail1_in;
   end

   // pending byte count stays below the sequence length and is zero when idle
   a_pending_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff.count == 2'd0) == (state_ff.exp_len == 3'd0) &&
      ((state_ff.count == 2'd0) || ({1'b0, state_ff.count} < state_ff.exp_len)))
      else $error("pending count out of step with sequence length");

   // no byte gives more than four results
   a_burst_size: assert property (@(posedge clock) disable iff (reset)
      remaining <= 4'd4)
      else $error("result burst larger than four");

   // a replacement always stands for one byte with the replacement code
   a_repl_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == {3'd1, REPL_CODE})
      else $error("malformed replacement result");

   // the input register never loads while its byte is blocked behind results
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("buffered byte lost before decode");

endmodule

### hdl/u8d_decode.sv
// combinational decode of one byte against the pending sequence state
`timescale 1ns / 1ps
module u8d_decode (
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   input  logic                   utf16_mode,
   input  u8d_pkg::u8d_state_type state_cur,
   output u8d_pkg::u8d_state_type state_nxt,
   output u8d_pkg::u8d_burst_type burst
);
   import u8d_pkg::*;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      priority if (b[7] == 1'b0)       lead_len = 3'd1;
      else if (b[7:5] == 3'b110)       lead_len = 3'd2;
      else if (b[7:4] == 4'b1110)      lead_len = 3'd3;
      else if (b[7:3] == 5'b11110)     lead_len = 3'd4;
      else                             lead_len = 3'd0;
   endfunction

   logic [CODE_W-1:0] cp2, cp3, cp4, cp, plane;
   logic              bad2, bad3, bad4, bad;
   logic [REP_W-1:0]  seq_len;
   logic              is_cont;
   logic [2:0]        new_len;

   assign is_cont = (in_byte[7:6] == 2'b10);
   assign new_len = lead_len(in_byte);

   assign cp2 = {10'd0, state_cur.store[0][4:0], in_byte[5:0]};
   assign cp3 = {5'd0, state_cur.store[0][3:0], state_cur.store[1][5:0], in_byte[5:0]};
   assign cp4 = {state_cur.store[0][2:0], state_cur.store[1][5:0],
                 state_cur.store[2][5:0], in_byte[5:0]};

   assign bad2 = (cp2 < MIN_TWO);
   assign bad3 = (cp3 < MIN_THREE) || ((cp3 >= SURR_LO) && (cp3 <= SURR_HI));
   assign bad4 = (cp4 < MIN_FOUR) || (cp4 > MAX_CODE);

   always_comb begin
      unique case (state_cur.exp_len)
         3'd2: begin
            cp      = cp2;
            bad     = bad2;
            seq_len = 3'd2;
         end
         3'd3: begin
            cp      = cp3;
            bad     = bad3;
            seq_len = 3'd3;
         end
         default: begin
            cp      = cp4;
            bad     = bad4;
            seq_len = 3'd4;
         end
      endcase
   end

   assign plane = cp - PLANE_OFFSET;

   always_comb begin
      logic as_lead;
      as_lead   = 1'b1;
      state_nxt = state_cur;
      burst     = '0;

      if (state_cur.count != 2'd0) begin
         if (is_cont) begin
            as_lead = 1'b0;
            if (({1'b0, state_cur.count} + 3'd1) >= state_cur.exp_len) begin
               // sequence complete
               state_nxt.count   = 2'd0;
               state_nxt.exp_len = 3'd0;
               if (bad) begin
                  burst.rep_cnt = seq_len;
               end else if (utf16_mode && (cp[20:16] != 5'd0)) begin
                  burst.tail_cnt    = 2'd2;
                  burst.tail0.code  = {5'd0, HIGH_PREFIX, plane[19:10]};
                  burst.tail0.rep   = 1'b0;
                  burst.tail0.src   = seq_len;
                  burst.tail1.code  = {5'd0, LOW_PREFIX, plane[9:0]};
                  burst.tail1.rep   = 1'b0;
                  burst.tail1.src   = 3'd0;
               end else begin
                  burst.tail_cnt    = 2'd1;
                  burst.tail0.code  = cp;
                  burst.tail0.rep   = 1'b0;
                  burst.tail0.src   = seq_len;
               end
            end else begin
               state_nxt.store[state_cur.count] = in_byte;
               state_nxt.count = state_cur.count + 2'd1;
               if (in_last) begin
                  // truncated at end of string
                  burst.rep_cnt     = {1'b0, state_cur.count} + 3'd1;
                  state_nxt.count   = 2'd0;
                  state_nxt.exp_len = 3'd0;
               end
            end
         end else begin
            // broken sequence: one replacement per pending byte
            burst.rep_cnt     = {1'b0, state_cur.count};
            state_nxt.count   = 2'd0;
            state_nxt.exp_len = 3'd0;
         end
      end

      if (as_lead) begin
         if (new_len == 3'd1) begin
            burst.tail_cnt   = 2'd1;
            burst.tail0.code = {13'd0, in_byte};
            burst.tail0.rep  = 1'b0;
            burst.tail0.src  = 3'd1;
         end else if ((new_len == 3'd0) || in_last) begin
            burst.tail_cnt   = 2'd1;
            burst.tail0.code = REPL_CODE;
            burst.tail0.rep  = 1'b1;
            burst.tail0.src  = 3'd1;
         end else begin
            state_nxt.store[0] = in_byte;
            state_nxt.count    = 2'd1;
            state_nxt.exp_len  = new_len;
         end
      end
   end

endmodule

### tb/testbench.sv
// self-checking testbench for the utf-8 stream decoder with replacement
`timescale 1ns / 1ps
module testbench;
   import u8d_pkg::*;

   localparam int MAX_CYCLES    = 100000;
   localparam int SETTLE_CYCLES = 8;     // input register and result stage plus margin
   localparam int REPORT_LIMIT  = 10;
   localparam logic CSR_UTF32   = 1'b0;
   localparam logic CSR_UTF16   = 1'b1;

   // one decoded result as the receiver should see it
   typedef struct {
      logic [CODE_W-1:0] code;
      logic              rep;
      logic [SRC_W-1:0]  src;
      logic              last;
   } char_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [20:0] code_value, [23:21] source_bytes
   logic        rsp_tuser;           // [0] is_replacement
   logic        rsp_tlast;

   utf8_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // decoder shadow state
   logic [7:0]   held_bytes [3];
   int           held_count = 0;
   int           seq_len = 0;
   logic         split_mode = 1'b0;

   char_result_type expected_chars [$];
   char_result_type burst_q [$];
   logic [7:0]      text_q [$];

   int mismatch_count = 0;
   int bytes_sent = 0;
   int cycle_count = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;

   function automatic int lead_class(input logic [7:0] b);
      unique casez (b)
         8'b0???_????: return 1;
         8'b110?_????: return 2;
         8'b1110_????: return 3;
         8'b1111_0???: return 4;
         default:      return 0;
      endcase
   endfunction

   function automatic void add_result(input logic [CODE_W-1:0] code, input logic rep,
                                      input logic [SRC_W-1:0] src);
      char_result_type r;
      r.code = code;
      r.rep  = rep;
      r.src  = src;
      r.last = 1'b0;
      burst_q.insert(burst_q.size(), r);
   endfunction

   function automatic void add_text_byte(input logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endfunction

   function automatic void flush_held();
      for (int i = 0; i < held_count; i++)
         add_result(REPL_CODE, 1'b1, 3'd1);
      held_count = 0;
      seq_len    = 0;
   endfunction

   // final continuation byte arrived: range checks only now
   function automatic void close_sequence(input logic [7:0] tail);
      logic [CODE_W-1:0] cp;
      logic [CODE_W-1:0] ofs;
      logic              bad;
      int                n;
      n = seq_len;
      unique case (seq_len)
         2: begin
            cp  = {10'd0, held_bytes[0][4:0], tail[5:0]};
            bad = cp < 21'h80;
         end
         3: begin
            cp  = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], tail[5:0]};
            bad = cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF);
         end
         default: begin
            cp  = {held_bytes[0][2:0], held_bytes[1][5:0], held_bytes[2][5:0], tail[5:0]};
            bad = cp < 21'h10000 || cp > 21'h10FFFF;
            n   = 4;
         end
      endcase
      if (bad) begin
         for (int i = 0; i < n; i++)
            add_result(REPL_CODE, 1'b1, 3'd1);
      end else if (split_mode && cp > 21'hFFFF) begin
         ofs = cp - 21'h10000;
         add_result(21'hD800 + ofs[19:10], 1'b0, n[2:0]);
         add_result(21'hDC00 + ofs[9:0], 1'b0, 3'd0);
      end else begin
         add_result(cp, 1'b0, n[2:0]);
      end
      held_count = 0;
      seq_len    = 0;
   endfunction

   // predicts the results of one transferred byte
   function automatic void decode_utf8_byte(input logic [7:0] b, input logic fin);
      logic as_lead;
      int   len;
      burst_q.delete();
      as_lead = 1'b1;
      if (held_count > 0) begin
         if (b[7:6] == 2'b10) begin
            as_lead = 1'b0;
            if (held_count + 1 >= seq_len) begin
               close_sequence(b);
            end else begin
               held_bytes[held_count] = b;
               held_count++;
               if (fin)
                  flush_held();
            end
         end else begin
            flush_held();
         end
      end
      if (as_lead) begin
         len = lead_class(b);
         if (len == 1) begin
            add_result({13'd0, b}, 1'b0, 3'd1);
         end else if (len == 0 || fin) begin
            add_result(REPL_CODE, 1'b1, 3'd1);
         end else begin
            held_bytes[0] = b;
            held_count    = 1;
            seq_len       = len;
         end
      end
      if (burst_q.size() > 0)
         burst_q[burst_q.size()-1].last = 1'b1;
      foreach (burst_q[i])
         expected_chars.insert(expected_chars.size(), burst_q[i]);
   endfunction

   // appends cp encoded in n bytes, with no range check
   function automatic void encode_as(input logic [CODE_W-1:0] cp, input int n);
      unique case (n)
         1: add_text_byte({1'b0, cp[6:0]});
         2: begin
            add_text_byte({3'b110, cp[10:6]});
            add_text_byte({2'b10, cp[5:0]});
         end
         3: begin
            add_text_byte({4'b1110, cp[15:12]});
            add_text_byte({2'b10, cp[11:6]});
            add_text_byte({2'b10, cp[5:0]});
         end
         default: begin
            add_text_byte({5'b11110, cp[20:18]});
            add_text_byte({2'b10, cp[17:12]});
            add_text_byte({2'b10, cp[11:6]});
            add_text_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // sender: random gaps, then hold the byte until it is taken
   task automatic send_byte(input logic [7:0] b, input logic fin);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      decode_utf8_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0)
         @(negedge clock);
      // bytes that only buffer leave nothing in the queue but may still be in flight
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_utf16_mode(input logic mode);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_wen   <= 1'b0;
      split_mode = mode;
   endtask

   task automatic send_text();
      foreach (text_q[i])
         send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   // one string of mostly valid characters with some broken ones mixed in
   task automatic send_random_string(input int max_chars);
      int                nchar;
      int                kind;
      int                n;
      logic [CODE_W-1:0] cp;
      nchar = $urandom_range(max_chars, 1);
      for (int c = 0; c < nchar; c++) begin
         kind = $urandom_range(99);
         if (kind < 22) begin
            encode_as(CODE_W'($urandom_range(8'h7F, 1)), 1);
         end else if (kind < 37) begin
            encode_as(CODE_W'($urandom_range(21'h7FF, 21'h80)), 2);
         end else if (kind < 52) begin
            cp = CODE_W'($urandom_range(21'hFFFF, 21'h800));
            if (cp >= 21'hD800 && cp <= 21'hDFFF)
               cp = cp ^ 21'h2000;
            encode_as(cp, 3);
         end else if (kind < 68) begin
            encode_as(CODE_W'($urandom_range(21'h10FFFF, 21'h10000)), 4);
         end else if (kind < 74) begin
            add_text_byte(8'($urandom_range(255, 1)));
         end else if (kind < 80) begin
            // truncated sequence, the next character breaks it
            n = $urandom_range(4, 2);
            encode_as(CODE_W'($urandom_range(21'h10FFFF, 21'h80)), n);
            repeat ($urandom_range(n - 1, 1)) void'(text_q.pop_back());
         end else if (kind < 86) begin
            // overlong form
            n = $urandom_range(4, 2);
            if (n == 2)
               cp = CODE_W'($urandom_range(21'h7F, 0));
            else if (n == 3)
               cp = CODE_W'($urandom_range(21'h7FF, 0));
            else
               cp = CODE_W'($urandom_range(21'hFFFF, 0));
            encode_as(cp, n);
         end else if (kind < 91) begin
            encode_as(CODE_W'($urandom_range(21'hDFFF, 21'hD800)), 3);
         end else if (kind < 96) begin
            encode_as(CODE_W'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
         end else begin
            add_text_byte(8'($urandom_range(8'hBF, 8'h80)));
         end
      end
      send_text();
   endtask

   task automatic test_single_bytes();
      send_byte(8'h00, 1'b0);   // zero byte decodes as u+0000
      send_byte(8'h80, 1'b0);   // stray continuation
      send_byte(8'hFF, 1'b1);   // invalid lead
   endtask

   task automatic test_valid_sequences();
      send_byte(8'hC2, 1'b0);   // smallest two-byte point
      send_byte(8'h80, 1'b0);
      send_byte(8'hEF, 1'b0);   // an encoded u+fffd is not a replacement
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBD, 1'b1);
   endtask

   task automatic test_broken_sequences();
      send_byte(8'hE1, 1'b0);   // ascii breaks a pending sequence
      send_byte(8'h80, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hC0, 1'b0);   // overlong, caught at the final byte
      send_byte(8'h80, 1'b0);
      send_byte(8'hED, 1'b0);   // surrogate
      send_byte(8'hA0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF5, 1'b0);   // above u+10ffff
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   task automatic test_truncation();
      send_byte(8'hF0, 1'b0);   // end of string flushes pending bytes
      send_byte(8'h90, 1'b1);
      send_byte(8'hE0, 1'b1);   // lead byte arriving last
   endtask

   task automatic test_surrogate_split();
      wait_until_drained();
      set_utf16_mode(CSR_UTF16);
      send_byte(8'hF4, 1'b0);   // u+10ffff as a surrogate pair
      send_byte(8'h8F, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
      wait_until_drained();
   endtask

   task automatic test_random_text(input int gap, input int stall, input logic mode,
                                   input int n_bytes);
      int start;
      wait_until_drained();
      set_utf16_mode(mode);
      gap_pct   = gap;
      stall_pct = stall;
      start     = bytes_sent;
      while (bytes_sent - start < n_bytes)
         send_random_string(8);
      wait_until_drained();
   endtask

   // receiver holds off while the sender keeps offering four-byte points
   task automatic test_backpressure();
      wait_until_drained();
      set_utf16_mode(CSR_UTF16);
      gap_pct     = 0;
      stall_pct   = 0;
      hold_cycles = 200;
      for (int i = 0; i < 12; i++)
         encode_as(CODE_W'($urandom_range(21'h10FFFF, 21'h10000)), 4);
      send_text();
      wait_until_drained();
   endtask

   // receiver: a counted hold-off first, otherwise random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      char_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: code %h rep %b src %0d last %b",
                        rsp_tdata[20:0], rsp_tuser, rsp_tdata[23:21], rsp_tlast);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata[20:0] !== want.code || rsp_tuser !== want.rep ||
                rsp_tdata[23:21] !== want.src || rsp_tlast !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: code %h/%h rep %b/%b src %0d/%0d last %b/%b",
                           want.code, rsp_tdata[20:0], want.rep, rsp_tuser,
                           want.src, rsp_tdata[23:21], want.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      set_utf16_mode(CSR_UTF32);
      test_single_bytes();
      test_valid_sequences();
      test_broken_sequences();
      test_truncation();
      test_surrogate_split();
      test_random_text(0, 0, CSR_UTF16, 45);
      test_random_text(53, 0, CSR_UTF32, 45);
      test_random_text(0, 53, CSR_UTF16, 45);
      test_random_text(14, 14, CSR_UTF32, 45);
      test_backpressure();
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
